/* rtl/tun_pkg.sv */
// ============================================================================
// tun_pkg
// Shared constants for the triangle unit normal block.
// ============================================================================
`default_nettype none

package tun_pkg;

    // Width of each result component (signed fixed point).
    localparam int OUT_BITS = 32;

    // Decoupling queue between the cross-product front and the length/divide back.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

`default_nettype wire

/* rtl/tun_if.sv */
// ============================================================================
// tun_if
// Valid/ready channels: triangle words in, unit normal words out.
// ============================================================================
`default_nettype none

interface tun_tri_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

interface tun_nrm_if;
    logic                                valid;
    logic                                ready;
    logic signed [tun_pkg::OUT_BITS-1:0] n_x;
    logic signed [tun_pkg::OUT_BITS-1:0] n_y;
    logic signed [tun_pkg::OUT_BITS-1:0] n_z;
    logic                                degenerate;

    modport source (
        output valid, n_x, n_y, n_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, n_x, n_y, n_z, degenerate,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/tun_front.sv */
// ============================================================================
// tun_front
// Edge vectors and exact cross product, three register stages.
// ============================================================================
`default_nettype none

module tun_front #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_BITS-1:0]  i_a_x,
    input  wire logic signed [COORD_BITS-1:0]  i_a_y,
    input  wire logic signed [COORD_BITS-1:0]  i_a_z,
    input  wire logic signed [COORD_BITS-1:0]  i_b_x,
    input  wire logic signed [COORD_BITS-1:0]  i_b_y,
    input  wire logic signed [COORD_BITS-1:0]  i_b_z,
    input  wire logic signed [COORD_BITS-1:0]  i_c_x,
    input  wire logic signed [COORD_BITS-1:0]  i_c_y,
    input  wire logic signed [COORD_BITS-1:0]  i_c_z,
    output logic                               o_valid,
    output logic [2:0][2*COORD_BITS+2:0]       o_p
);
    localparam int C = COORD_BITS;
    localparam int E = C + 1;        // edge width
    localparam int P = 2 * E + 1;    // cross component width

    logic                r_v1, r_v2, r_v3;
    logic signed [E-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [2*E-1:0] r_m [0:5];
    logic [2:0][P-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edges u = b - a, v = c - a
            r_ux <= $signed({i_b_x[C-1], i_b_x}) - $signed({i_a_x[C-1], i_a_x});
            r_uy <= $signed({i_b_y[C-1], i_b_y}) - $signed({i_a_y[C-1], i_a_y});
            r_uz <= $signed({i_b_z[C-1], i_b_z}) - $signed({i_a_z[C-1], i_a_z});
            r_vx <= $signed({i_c_x[C-1], i_c_x}) - $signed({i_a_x[C-1], i_a_x});
            r_vy <= $signed({i_c_y[C-1], i_c_y}) - $signed({i_a_y[C-1], i_a_y});
            r_vz <= $signed({i_c_z[C-1], i_c_z}) - $signed({i_a_z[C-1], i_a_z});
            // six products
            r_m[0] <= r_uy * r_vz;
            r_m[1] <= r_uz * r_vy;
            r_m[2] <= r_uz * r_vx;
            r_m[3] <= r_ux * r_vz;
            r_m[4] <= r_ux * r_vy;
            r_m[5] <= r_uy * r_vx;
            // differences, one bit wider
            r_p[0] <= $signed({r_m[0][2*E-1], r_m[0]}) - $signed({r_m[1][2*E-1], r_m[1]});
            r_p[1] <= $signed({r_m[2][2*E-1], r_m[2]}) - $signed({r_m[3][2*E-1], r_m[3]});
            r_p[2] <= $signed({r_m[4][2*E-1], r_m[4]}) - $signed({r_m[5][2*E-1], r_m[5]});
        end
    end

    assign o_valid = r_v3;
    assign o_p     = r_p;

endmodule

`default_nettype wire

/* rtl/tun_queue.sv */
// ============================================================================
// tun_queue
// Small register FIFO between front and back.
// ============================================================================
`default_nettype none

module tun_queue #(
    parameter int WIDTH = 153
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW    = tun_pkg::QUEUE_AW;
    localparam int DEPTH = tun_pkg::QUEUE_DEPTH;

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

/* rtl/tun_len.sv */
// ============================================================================
// tun_len
// Magnitudes, squared length and pipelined floor square root.
// ============================================================================
`default_nettype none

module tun_len #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [2:0][2*COORD_BITS+2:0] i_p,
    output logic                            o_valid,
    output logic [2*COORD_BITS+2:0]         o_len,
    output logic [2:0][2*COORD_BITS+1:0]    o_mag,
    output logic [2:0]                      o_neg
);
    localparam int P  = 2 * COORD_BITS + 3;
    localparam int MB = P - 1;          // magnitude width
    localparam int H  = MB / 2;         // half of a magnitude
    localparam int S  = 2 * MB + 2;     // squared length width
    localparam int R  = S / 2;          // root width, one stage per bit

    logic                 r_v0, r_v1, r_v2;
    logic [2:0][MB-1:0]   r_mag0, r_mag1, r_mag2;
    logic [2:0]           r_neg0, r_neg1, r_neg2;
    logic [2:0][MB-1:0]   r_hh, r_hl, r_ll;
    logic [2:0][2*MB-1:0] r_sq;

    logic                 r_sv   [0:R];
    logic [S-1:0]         r_rem  [0:R];
    logic [S-1:0]         r_res  [0:R];
    logic [2:0][MB-1:0]   r_smag [0:R];
    logic [2:0]           r_sneg [0:R];

    logic [2:0][P-1:0]    n_abs;
    logic [2:0][2*MB-1:0] n_hl_sh;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_abs[c]   = i_p[c][P-1] ? (~i_p[c] + 1'b1) : i_p[c];
            n_hl_sh[c] = {{(H-1){1'b0}}, r_hl[c], {(H+1){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_sv[0]  <= 1'b0;
        end else if (i_en) begin
            r_v0     <= i_valid;
            r_v1     <= r_v0;
            r_v2     <= r_v1;
            r_sv[0]  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_mag0[c] <= n_abs[c][MB-1:0];
                r_neg0[c] <= i_p[c][P-1];
                // square split into halves
                r_hh[c]   <= r_mag0[c][MB-1:H] * r_mag0[c][MB-1:H];
                r_hl[c]   <= r_mag0[c][MB-1:H] * r_mag0[c][H-1:0];
                r_ll[c]   <= r_mag0[c][H-1:0]  * r_mag0[c][H-1:0];
                r_sq[c]   <= {r_hh[c], r_ll[c]} + n_hl_sh[c];
            end
            r_mag1    <= r_mag0;
            r_neg1    <= r_neg0;
            r_mag2    <= r_mag1;
            r_neg2    <= r_neg1;
            r_rem[0]  <= S'(r_sq[0]) + S'(r_sq[1]) + S'(r_sq[2]);
            r_res[0]  <= '0;
            r_smag[0] <= r_mag2;
            r_sneg[0] <= r_neg2;
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < R; k++) begin : g_sqrt
        localparam int           JP    = 2 * (R - 1 - k);
        localparam logic [S-1:0] C_BIT = S'(1) << JP;

        logic [S:0]   n_t;
        logic         n_ge;
        logic [S-1:0] n_rem, n_res;

        always_comb begin
            n_t  = {1'b0, r_res[k]} + {1'b0, C_BIT};
            n_ge = ({1'b0, r_rem[k]} >= n_t);
            if (n_ge) begin
                n_rem = r_rem[k] - n_t[S-1:0];
                n_res = (r_res[k] >> 1) + C_BIT;
            end else begin
                n_rem = r_rem[k];
                n_res = r_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_res[k+1]  <= n_res;
                r_smag[k+1] <= r_smag[k];
                r_sneg[k+1] <= r_sneg[k];
            end
        end
    end

    assign o_valid = r_sv[R];
    assign o_len   = r_res[R][R-1:0];
    assign o_mag   = r_smag[R];
    assign o_neg   = r_sneg[R];

endmodule

`default_nettype wire

/* rtl/tun_div.sv */
// ============================================================================
// tun_div
// Pipelined restoring divide: |p| * 2^FRAC_BITS / length, three lanes.
// ============================================================================
`default_nettype none

module tun_div #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 30
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [2*COORD_BITS+2:0]    i_len,
    input  wire logic [2:0][2*COORD_BITS+1:0] i_mag,
    input  wire logic [2:0]                 i_neg,
    output logic                            o_valid,
    output logic [2:0][FRAC_BITS:0]         o_q,
    output logic [2:0]                      o_neg,
    output logic                            o_degen
);
    localparam int R  = 2 * COORD_BITS + 3;   // divisor width
    localparam int MB = R - 1;                // dividend magnitude width
    localparam int RW = R + 1;                // partial remainder width
    localparam int Q  = FRAC_BITS + 1;        // quotient width
    localparam int N  = FRAC_BITS + 1;        // stages

    logic               r_dv   [0:N];
    logic [2:0][RW-1:0] r_drem [0:N];
    logic [2:0][Q-1:0]  r_dq   [0:N];
    logic [R-1:0]       r_dd   [0:N];
    logic [2:0]         r_dneg [0:N];
    logic               r_ddeg [0:N];

    logic               n_degen;

    assign n_degen = (i_len == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_drem[0][c] <= {2'b00, i_mag[c]};
            end
            r_dq[0]   <= '0;
            // zero length divides by one
            r_dd[0]   <= n_degen ? R'(1) : i_len;
            r_dneg[0] <= i_neg;
            r_ddeg[0] <= n_degen;
        end
    end

    // quotient bits FRAC_BITS down to 0; remainder stays below the divisor
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [2:0][RW-1:0] n_sh, n_rem;
        logic [2:0][Q-1:0]  n_q;
        logic [2:0]         n_ge;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                if (k == 0) n_sh[c] = r_drem[k][c];
                else        n_sh[c] = {r_drem[k][c][RW-2:0], 1'b0};
                n_ge[c]  = (n_sh[c] >= {1'b0, r_dd[k]});
                n_rem[c] = n_ge[c] ? (n_sh[c] - {1'b0, r_dd[k]}) : n_sh[c];
                n_q[c]   = {r_dq[k][c][Q-2:0], n_ge[c]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[k+1] <= n_rem;
                r_dq[k+1]   <= n_q;
                r_dd[k+1]   <= r_dd[k];
                r_dneg[k+1] <= r_dneg[k];
                r_ddeg[k+1] <= r_ddeg[k];
            end
        end
    end

    assign o_valid = r_dv[N];
    assign o_q     = r_dq[N];
    assign o_neg   = r_dneg[N];
    assign o_degen = r_ddeg[N];

    // magnitude never exceeds the length, so the quotient fits FRAC_BITS+1 bits
    if (MB >= RW) begin : g_bad_width
        $error("tun_div: remainder too narrow");
    end

endmodule

`default_nettype wire

/* rtl/triangle_unit_normal_top.sv */
// ============================================================================
// triangle_unit_normal_top
// Unit normal of one triangle per word, signed fixed point.
// ============================================================================
// Takes one triangle word per clock while the queue has room (three vertices,
// COORD_BITS-bit signed coordinates) and returns one word per triangle: the
// cross product of the edges b-a and c-a, each component divided by the floor
// integer square root of the squared length and scaled by 2^FRAC_BITS,
// truncated toward zero. A triangle whose length comes out zero gives a zero
// vector with degenerate set. Sustained rate is one word per cycle while the
// output is not stalled: every unit is fully pipelined (square root one bit per
// stage, divider one quotient bit per stage); the square root and divide chains
// make up most of the pipeline. The front (edges, cross product) and the back
// (length, divide) are split by a 4-word queue, so output backpressure freezes
// the back while the front keeps taking words until the queue fills; the queue
// lets new words be accepted while a finished one waits in the output register.
// ============================================================================
`default_nettype none

module triangle_unit_normal_top #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 30
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tun_tri_if.sink    i_tri,
    tun_nrm_if.source  o_nrm
);
    localparam int P   = 2 * COORD_BITS + 3;   // cross component width
    localparam int MB  = P - 1;                // magnitude width
    localparam int Q   = FRAC_BITS + 1;        // quotient width
    localparam int OB  = tun_pkg::OUT_BITS;
    localparam logic signed [OB-1:0] C_ONE = OB'(1) << FRAC_BITS;

    // ---------------------------------------------------------------- front
    logic              f_en;
    logic              f_valid;
    logic [2:0][P-1:0] f_p;

    logic              q_push, q_pop, q_full, q_empty;
    logic [3*P-1:0]    q_data;
    logic [2:0][P-1:0] q_p;

    // front only moves when the queue has room
    assign f_en        = !q_full;
    assign i_tri.ready = f_en;

    tun_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (f_en),
        .i_valid (i_tri.valid),
        .i_a_x   (i_tri.a_x),
        .i_a_y   (i_tri.a_y),
        .i_a_z   (i_tri.a_z),
        .i_b_x   (i_tri.b_x),
        .i_b_y   (i_tri.b_y),
        .i_b_z   (i_tri.b_z),
        .i_c_x   (i_tri.c_x),
        .i_c_y   (i_tri.c_y),
        .i_c_z   (i_tri.c_z),
        .o_valid (f_valid),
        .o_p     (f_p)
    );

    // ---------------------------------------------------------------- queue
    assign q_push = f_en && f_valid;

    tun_queue #(
        .WIDTH (3 * P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_p),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign q_p = q_data;

    // ----------------------------------------------------------------- back
    // whole back advances whenever the output register is free or drains
    logic               b_en;
    logic               l_valid;
    logic [P-1:0]       l_len;
    logic [2:0][MB-1:0] l_mag;
    logic [2:0]         l_neg;
    logic               d_valid;
    logic [2:0][Q-1:0]  d_q;
    logic [2:0]         d_neg;
    logic               d_degen;

    logic               r_out_valid;
    logic [2:0][OB-1:0] r_out_n;
    logic               r_out_degen;
    logic [2:0][OB-1:0] n_out_n;

    assign b_en  = !r_out_valid || o_nrm.ready;
    assign q_pop = b_en && !q_empty;

    tun_len #(
        .COORD_BITS (COORD_BITS)
    ) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_en),
        .i_valid (!q_empty),
        .i_p     (q_p),
        .o_valid (l_valid),
        .o_len   (l_len),
        .o_mag   (l_mag),
        .o_neg   (l_neg)
    );

    tun_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_en),
        .i_valid (l_valid),
        .i_len   (l_len),
        .i_mag   (l_mag),
        .i_neg   (l_neg),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_neg   (d_neg),
        .o_degen (d_degen)
    );

    // ------------------------------------------------------- output register
    // sign goes back on here; quotient is at most 2^FRAC_BITS
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_out_n[c] = d_neg[c] ? (OB'(0) - OB'(d_q[c])) : OB'(d_q[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && d_valid) begin
            r_out_n     <= n_out_n;
            r_out_degen <= d_degen;
        end
    end

    assign o_nrm.valid      = r_out_valid;
    assign o_nrm.n_x        = r_out_n[0];
    assign o_nrm.n_y        = r_out_n[1];
    assign o_nrm.n_z        = r_out_n[2];
    assign o_nrm.degenerate = r_out_degen;

    // ------------------------------------------------------------ assertions
    // queue is never written while full
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // degenerate words carry a zero vector
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && o_nrm.degenerate) |->
        (o_nrm.n_x == '0 && o_nrm.n_y == '0 && o_nrm.n_z == '0))
        else $error("degenerate word with nonzero normal");

    // a proper triangle never gives the zero vector
    a_nondegen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && !o_nrm.degenerate) |->
        (o_nrm.n_x != '0 || o_nrm.n_y != '0 || o_nrm.n_z != '0))
        else $error("zero normal on a proper triangle");

    // every component within one unit
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrm.valid |->
        ($signed(o_nrm.n_x) <= C_ONE && $signed(o_nrm.n_x) >= -C_ONE &&
         $signed(o_nrm.n_y) <= C_ONE && $signed(o_nrm.n_y) >= -C_ONE &&
         $signed(o_nrm.n_z) <= C_ONE && $signed(o_nrm.n_z) >= -C_ONE))
        else $error("normal component beyond one unit");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ============================================================================
// testbench
// Self-checking bench for the triangle unit normal block.
// ============================================================================
// Triangle words go in from a queue that an initial block fills: a short
// directed set (extremes, degenerate shapes, axis-aligned normals), then
// random triangles of mixed coordinate sizes. A clocked driver and monitor
// idle at random. Each accepted word is predicted at full width and the
// expected normal is queued; the monitor compares every output word.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    localparam int CB = 24;
    localparam int FB = 30;
    localparam int LATENCY = 2 * CB + FB + 14;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } tri_t;

    typedef struct packed {
        logic signed [tun_pkg::OUT_BITS-1:0] nx, ny, nz;
        logic                                degen;
    } nrm_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tun_tri_if #(.COORD_BITS(CB)) tri_ch ();
    tun_nrm_if                    nrm_ch ();

    triangle_unit_normal_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch),
        .o_nrm  (nrm_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    tri_t pending_tris[$];
    nrm_t expected_normals[$];
    int   errors = 0;
    bit   stim_done = 0;
    bit   drain_hold = 0;   // sender waits for all results while set

    // Floor square root of a nonnegative 160-bit value, bit by bit.
    function automatic logic [159:0] isqrt160(logic [159:0] n);
        logic [159:0] res, bitv, t;
        res  = '0;
        bitv = 160'd1 << 158;
        while (bitv != 0) begin
            t = res + bitv;
            if (n >= t) begin
                n   = n - t;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic nrm_t unit_normal(tri_t t);
        logic signed [159:0] ux, uy, uz, vx, vy, vz;
        logic signed [159:0] p[3];
        logic [159:0]        sq, len, mag, q;
        nrm_t                r;
        logic [tun_pkg::OUT_BITS-1:0] comp[3];
        ux = 160'(t.bx) - 160'(t.ax);
        uy = 160'(t.by) - 160'(t.ay);
        uz = 160'(t.bz) - 160'(t.az);
        vx = 160'(t.cx) - 160'(t.ax);
        vy = 160'(t.cy) - 160'(t.ay);
        vz = 160'(t.cz) - 160'(t.az);
        p[0] = uy * vz - uz * vy;
        p[1] = uz * vx - ux * vz;
        p[2] = ux * vy - uy * vx;
        sq  = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
        len = isqrt160(sq);
        r.degen = (len == 0);
        if (r.degen) len = 160'd1;
        for (int i = 0; i < 3; i++) begin
            mag = (p[i] < 0) ? -p[i] : p[i];
            q   = (mag << FB) / len;
            comp[i] = (p[i] < 0) ? -q[tun_pkg::OUT_BITS-1:0] : q[tun_pkg::OUT_BITS-1:0];
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        return r;
    endfunction

    // Random coordinate: mostly small ranges, some full width.
    function automatic logic [CB-1:0] rand_coord(int sz);
        case (sz)
            0: return CB'($signed($urandom_range(0, 15)) - 8);
            1: return CB'($signed($urandom_range(0, 4095)) - 2048);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        int   sz, kind;
        sz   = $urandom_range(0, 2);
        kind = $urandom_range(0, 9);
        t = {rand_coord(sz), rand_coord(sz), rand_coord(sz), rand_coord(sz),
             rand_coord(sz), rand_coord(sz), rand_coord(sz), rand_coord(sz),
             rand_coord(sz)};
        if (kind == 0) begin
            // coincident b and a: degenerate
            t.bx = t.ax; t.by = t.ay; t.bz = t.az;
        end else if (kind == 1) begin
            // c on the line through a and b
            t.cx = CB'(t.ax + 2 * (t.bx - t.ax));
            t.cy = CB'(t.ay + 2 * (t.by - t.ay));
            t.cz = CB'(t.az + 2 * (t.bz - t.az));
        end
        return t;
    endfunction

    localparam logic signed [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

    initial begin
        // all zero, all coincident
        pending_tris.push_back('0);
        pending_tris.push_back({9{MAXC}});
        pending_tris.push_back({9{MINC}});
        // axis-aligned normals: +z, -z, +x, +y
        pending_tris.push_back({CB'(0), CB'(0), CB'(0), CB'(1), CB'(0), CB'(0),
                                CB'(0), CB'(1), CB'(0)});
        pending_tris.push_back({CB'(0), CB'(0), CB'(0), CB'(0), CB'(1), CB'(0),
                                CB'(1), CB'(0), CB'(0)});
        pending_tris.push_back({CB'(0), CB'(0), CB'(0), CB'(0), CB'(1), CB'(0),
                                CB'(0), CB'(0), CB'(1)});
        pending_tris.push_back({CB'(0), CB'(0), CB'(0), CB'(0), CB'(0), CB'(1),
                                CB'(1), CB'(0), CB'(0)});
        // extreme edges: full span in each axis
        pending_tris.push_back({MINC, MINC, MINC, MAXC, MINC, MINC,
                                MINC, MAXC, MINC});
        pending_tris.push_back({MAXC, MAXC, MAXC, MINC, MAXC, MINC,
                                MAXC, MINC, MINC});
        pending_tris.push_back({MINC, MAXC, MINC, MAXC, MINC, MAXC,
                                MAXC, MAXC, MINC});
        pending_tris.push_back({MAXC, MINC, MAXC, MINC, MAXC, MINC,
                                MINC, MINC, MAXC});
        // collinear, large
        pending_tris.push_back({CB'(0), CB'(0), CB'(0), MAXC, MAXC, MAXC,
                                CB'(MINC + 1), CB'(MINC + 1), CB'(MINC + 1)});
        // tilted small triangles
        pending_tris.push_back({CB'(1), CB'(2), CB'(3), CB'(4), CB'(6), CB'(8),
                                CB'(-3), CB'(5), CB'(-7)});
        pending_tris.push_back({CB'(-1), CB'(-1), CB'(-1), CB'(1), CB'(1), CB'(-1),
                                CB'(1), CB'(-1), CB'(1)});
        for (int i = 0; i < 700; i++) pending_tris.push_back(rand_tri());
        // the last word is still on the channel after the pop; wait for its accept
        wait (pending_tris.size() == 0);
        @(posedge i_clk);
        wait (!tri_ch.valid);
        // full drain before the second half
        drain_hold = 1;
        wait (expected_normals.size() == 0);
        drain_hold = 0;
        for (int i = 0; i < 800; i++) pending_tris.push_back(rand_tri());
        wait (pending_tris.size() == 0);
        @(posedge i_clk);
        wait (!tri_ch.valid);
        stim_done = 1;
    end

    // Driver
    int send_gap = 0;
    initial begin
        tri_ch.valid = 1'b0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y,
         tri_ch.b_z, tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        nrm_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        tri_t t;
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
        end else begin
            if (tri_ch.valid && tri_ch.ready) begin
                t = {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y,
                     tri_ch.b_z, tri_ch.c_x, tri_ch.c_y, tri_ch.c_z};
                expected_normals.push_back(unit_normal(t));
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 7) == 0) send_gap = 0;
            end
            if (!(tri_ch.valid && !tri_ch.ready)) begin
                if (send_gap > 0 || drain_hold || pending_tris.size() == 0) begin
                    tri_ch.valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    t = pending_tris.pop_front();
                    tri_ch.valid <= 1'b1;
                    {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y,
                     tri_ch.b_z, tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= t;
                end
            end
        end
    end

    // Monitor: random stalls on the result side
    int stall_left = 0;
    always @(posedge i_clk) begin
        nrm_t got, want;
        if (i_rst_n) begin
            if (nrm_ch.valid && nrm_ch.ready) begin
                got = {nrm_ch.n_x, nrm_ch.n_y, nrm_ch.n_z, nrm_ch.degenerate};
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors++;
                end else begin
                    want = expected_normals.pop_front();
                    if (got.nx !== want.nx) begin
                        $display("%0t: n_x expected %h actual %h", $time, want.nx, got.nx);
                        errors++;
                    end
                    if (got.ny !== want.ny) begin
                        $display("%0t: n_y expected %h actual %h", $time, want.ny, got.ny);
                        errors++;
                    end
                    if (got.nz !== want.nz) begin
                        $display("%0t: n_z expected %h actual %h", $time, want.nz, got.nz);
                        errors++;
                    end
                    if (got.degen !== want.degen) begin
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 want.degen, got.degen);
                        errors++;
                    end
                end
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                nrm_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                nrm_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, then wait for the end of stimulus and the pipeline to drain
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_normals.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && expected_normals.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: 1514 words with random send gaps and result stalls, plus drains
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire

/* triangle_unit_normal_top.f */
rtl/tun_pkg.sv
rtl/tun_if.sv
rtl/tun_front.sv
rtl/tun_queue.sv
rtl/tun_len.sv
rtl/tun_div.sv
rtl/triangle_unit_normal_top.sv
tb/testbench.sv
